@@ hdl/s3rp_pkg.sv @@
// s3rp_pkg: word types, round constants and SHA-256 round functions for the
// three-round midstate precompute block.
// No dependencies; used by sha256_three_round_precompute.
package s3rp_pkg;

    localparam int unsigned WORD_W    = 32;
    localparam int unsigned NUM_ROUND = 3;
    localparam int unsigned NUM_STATE = 8;

    typedef logic [WORD_W-1:0] word_t;

    // Round constants K0..K2
    localparam word_t ROUND_K [NUM_ROUND] = '{32'h428a2f98, 32'h71374491, 32'hb5c0fbcf};

    // Incoming word: midstate plus the first three message words
    typedef struct packed {
        word_t mid_a;
        word_t mid_b;
        word_t mid_c;
        word_t mid_d;
        word_t mid_e;
        word_t mid_f;
        word_t mid_g;
        word_t mid_h;
        word_t msg_w0;
        word_t msg_w1;
        word_t msg_w2;
    } mid_word_t;

    // Outgoing word, last round first
    typedef struct packed {
        word_t a_after_round3;
        word_t a_after_round2;
        word_t a_after_round1;
        word_t e_after_round3;
        word_t e_after_round2;
        word_t e_after_round1;
    } pre_word_t;

    // Data carried down the pipeline
    typedef struct packed {
        logic [NUM_STATE-1:0][WORD_W-1:0] st;   // working words a..h, index 0 = a
        logic [NUM_ROUND-1:0][WORD_W-1:0] msg;  // message words per round
        word_t                            t1;
        word_t                            t2;
        logic [NUM_ROUND-1:0][WORD_W-1:0] a_hist;
        logic [NUM_ROUND-1:0][WORD_W-1:0] e_hist;
    } pipe_t;

    function automatic word_t big_sigma0(input word_t x);
        return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
    endfunction

    function automatic word_t big_sigma1(input word_t x);
        return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
    endfunction

    function automatic word_t choose(input word_t e, input word_t f, input word_t g);
        return (e & f) ^ (~e & g);
    endfunction

    function automatic word_t major(input word_t a, input word_t b, input word_t c);
        return (a & b) ^ (a & c) ^ (b & c);
    endfunction

endpackage

@@ hdl/sha256_three_round_precompute.sv @@
// sha256_three_round_precompute: six-stage pipeline running SHA-256 rounds
// one to three on a midstate. Depends on s3rp_pkg.
//
// Usage:
//   mid channel (mid_valid/mid_ready/mid_data) takes one word: midstate a..h
//   and message words w0..w2. pre channel (pre_valid/pre_ready/pre_data)
//   returns the new a and e after each of the three rounds, round three first.
//   Each round takes two stages: the first forms T1 and T2, the second adds
//   them into the new a and e and shifts the working words. The first stage
//   loads at the accepting edge, and the word then moves through the later
//   stages until pre_valid rises with it; throughput is one word per cycle
//   while pre_ready holds, since every stage loads while the next one moves.
//   Each stage's valid bit travels with its data. A stage loads when it is
//   empty or the stage after it moves, so a stall at pre_ready fills the
//   empty stages first and only then drops mid_ready; nothing is lost or
//   repeated. Up to six words are in flight.
//   Reset (rst_n low, asynchronous) empties the pipeline; no state is kept
//   between words.
module sha256_three_round_precompute (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  mid_valid,
    output logic                  mid_ready,
    input  s3rp_pkg::mid_word_t   mid_data,
    output logic                  pre_valid,
    input  logic                  pre_ready,
    output s3rp_pkg::pre_word_t   pre_data
);

    localparam int unsigned NUM_STAGE = 2 * s3rp_pkg::NUM_ROUND;

    s3rp_pkg::pipe_t              data_reg  [NUM_STAGE];
    logic [NUM_STAGE-1:0]         valid_reg;
    s3rp_pkg::pipe_t              data_next [NUM_STAGE];
    logic [NUM_STAGE:0]           stage_ready;
    s3rp_pkg::pipe_t              in_pipe;

    // Unpack the incoming word into pipeline form
    always_comb
    begin
        in_pipe        = '0;
        in_pipe.st[0]  = mid_data.mid_a;
        in_pipe.st[1]  = mid_data.mid_b;
        in_pipe.st[2]  = mid_data.mid_c;
        in_pipe.st[3]  = mid_data.mid_d;
        in_pipe.st[4]  = mid_data.mid_e;
        in_pipe.st[5]  = mid_data.mid_f;
        in_pipe.st[6]  = mid_data.mid_g;
        in_pipe.st[7]  = mid_data.mid_h;
        in_pipe.msg[0] = mid_data.msg_w0;
        in_pipe.msg[1] = mid_data.msg_w1;
        in_pipe.msg[2] = mid_data.msg_w2;
    end

    // Ready chain: a stage can load when empty or when its successor moves
    assign stage_ready[NUM_STAGE] = pre_ready;
    assign mid_ready              = stage_ready[0];

    for (genvar s = 0; s < NUM_STAGE; s++)
    begin : g_stage
        localparam int unsigned RND = s / 2;

        s3rp_pkg::pipe_t src;
        logic            src_valid;

        if (s == 0)
        begin : g_first
            assign src       = in_pipe;
            assign src_valid = mid_valid;
        end
        else
        begin : g_rest
            assign src       = data_reg[s-1];
            assign src_valid = valid_reg[s-1];
        end

        assign stage_ready[s] = !valid_reg[s] || stage_ready[s+1];

        if ((s % 2) == 0)
        begin : g_half1
            // T1 and T2 of this round
            always_comb
            begin
                data_next[s]    = src;
                data_next[s].t1 = src.st[7] + s3rp_pkg::big_sigma1(src.st[4])
                                + s3rp_pkg::choose(src.st[4], src.st[5], src.st[6])
                                + s3rp_pkg::ROUND_K[RND] + src.msg[RND];
                data_next[s].t2 = s3rp_pkg::big_sigma0(src.st[0])
                                + s3rp_pkg::major(src.st[0], src.st[1], src.st[2]);
            end
        end
        else
        begin : g_half2
            // New a and e, shift the working words
            always_comb
            begin
                data_next[s]             = src;
                data_next[s].st[7]       = src.st[6];
                data_next[s].st[6]       = src.st[5];
                data_next[s].st[5]       = src.st[4];
                data_next[s].st[4]       = src.st[3] + src.t1;
                data_next[s].st[3]       = src.st[2];
                data_next[s].st[2]       = src.st[1];
                data_next[s].st[1]       = src.st[0];
                data_next[s].st[0]       = src.t1 + src.t2;
                data_next[s].a_hist[RND] = src.t1 + src.t2;
                data_next[s].e_hist[RND] = src.st[3] + src.t1;
            end
        end

        // Stage valid bit
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[s] <= 1'b0;
            end
            else if (stage_ready[s])
            begin
                valid_reg[s] <= src_valid;
            end
        end

        // Stage payload
        always_ff @(posedge clk)
        begin
            if (stage_ready[s] && src_valid)
            begin
                data_reg[s] <= data_next[s];
            end
        end

        // A stalled stage keeps its word
        a_stage_hold: assert property (@(posedge clk) disable iff (!rst_n)
            (valid_reg[s] && !stage_ready[s+1]) |=> (valid_reg[s] && $stable(data_reg[s])))
            else $error("stage %0d lost or changed a stalled word", s);
    end

    // Result word, last round first
    assign pre_valid                = valid_reg[NUM_STAGE-1];
    assign pre_data.a_after_round3  = data_reg[NUM_STAGE-1].a_hist[2];
    assign pre_data.a_after_round2  = data_reg[NUM_STAGE-1].a_hist[1];
    assign pre_data.a_after_round1  = data_reg[NUM_STAGE-1].a_hist[0];
    assign pre_data.e_after_round3  = data_reg[NUM_STAGE-1].e_hist[2];
    assign pre_data.e_after_round2  = data_reg[NUM_STAGE-1].e_hist[1];
    assign pre_data.e_after_round1  = data_reg[NUM_STAGE-1].e_hist[0];

    // Input backpressure only when every stage is full and the output stalls
    a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !mid_ready |-> ((&valid_reg) && !pre_ready))
        else $error("input stalled while the pipeline has room");

    // An accepted word lands in the first stage
    a_accept_load: assert property (@(posedge clk) disable iff (!rst_n)
        (mid_valid && mid_ready) |=> valid_reg[0])
        else $error("accepted word not captured");

    // Final stage history agrees with its working words
    a_hist_match: assert property (@(posedge clk) disable iff (!rst_n)
        pre_valid |-> (pre_data.a_after_round3 == data_reg[NUM_STAGE-1].st[0]
                    && pre_data.e_after_round3 == data_reg[NUM_STAGE-1].st[4]))
        else $error("round history out of step with working words");

endmodule

@@ verif/s3rp_round_checker.sv @@
// s3rp_round_checker: watches both channels of sha256_three_round_precompute,
// predicts every result word from the accepted midstate word and compares.
// Depends on s3rp_pkg for the word types.
module s3rp_round_checker (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                mid_valid,
    input  logic                mid_ready,
    input  s3rp_pkg::mid_word_t mid_data,
    input  logic                pre_valid,
    input  logic                pre_ready,
    input  s3rp_pkg::pre_word_t pre_data,
    output int                  fail_count,
    output int                  pending,
    output int                  words_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    // SHA-256 round constants for rounds one to three
    localparam s3rp_pkg::word_t RND_K [3] = '{32'h428a2f98, 32'h71374491, 32'hb5c0fbcf};

    s3rp_pkg::pre_word_t precalc_q [$];
    int                  errs = 0;
    int                  seen = 0;

    function automatic s3rp_pkg::word_t ror(input s3rp_pkg::word_t x, input int unsigned s);
        return (x >> s) | (x << (s3rp_pkg::WORD_W - s));
    endfunction

    function automatic string field_label(input int idx);
        case (idx)
            0:       return "a_after_round3";
            1:       return "a_after_round2";
            2:       return "a_after_round1";
            3:       return "e_after_round3";
            4:       return "e_after_round2";
            default: return "e_after_round1";
        endcase
    endfunction

    // Three compression rounds; keeps new a and e of each round
    function automatic s3rp_pkg::pre_word_t run_three_rounds(input s3rp_pkg::mid_word_t m);
        s3rp_pkg::word_t     st [8];
        s3rp_pkg::word_t     w [3];
        s3rp_pkg::word_t     s0, s1, ch, mj, t1, t2;
        s3rp_pkg::word_t     a_new [3];
        s3rp_pkg::word_t     e_new [3];
        s3rp_pkg::pre_word_t r;
        st = '{m.mid_a, m.mid_b, m.mid_c, m.mid_d, m.mid_e, m.mid_f, m.mid_g, m.mid_h};
        w  = '{m.msg_w0, m.msg_w1, m.msg_w2};
        for (int i = 0; i < 3; i++)
        begin
            s1 = ror(st[4], 6) ^ ror(st[4], 11) ^ ror(st[4], 25);
            ch = (st[4] & st[5]) ^ (~st[4] & st[6]);
            t1 = st[7] + s1 + ch + RND_K[i] + w[i];
            s0 = ror(st[0], 2) ^ ror(st[0], 13) ^ ror(st[0], 22);
            mj = (st[0] & st[1]) ^ (st[0] & st[2]) ^ (st[1] & st[2]);
            t2 = s0 + mj;
            for (int j = 7; j > 0; j--)
            begin
                st[j] = st[j-1];
            end
            // st[4] now holds the old d
            st[4] = st[4] + t1;
            st[0] = t1 + t2;
            a_new[i] = st[0];
            e_new[i] = st[4];
        end
        r.a_after_round3 = a_new[2];
        r.a_after_round2 = a_new[1];
        r.a_after_round1 = a_new[0];
        r.e_after_round3 = e_new[2];
        r.e_after_round2 = e_new[1];
        r.e_after_round1 = e_new[0];
        return r;
    endfunction

    // Check results against the oldest prediction, then log new input words
    always @(posedge clk)
    begin
        logic [5:0][s3rp_pkg::WORD_W-1:0] got;
        logic [5:0][s3rp_pkg::WORD_W-1:0] want;
        if (rst_n)
        begin
            if (pre_valid && pre_ready)
            begin
                if (precalc_q.size() == 0)
                begin
                    $error("result word with nothing outstanding: %h", pre_data);
                    errs++;
                end
                else
                begin
                    want = precalc_q.pop_front();
                    got  = pre_data;
                    for (int i = 0; i < 6; i++)
                    begin
                        if (got[5-i] !== want[5-i])
                        begin
                            $error("%s: expected %h, actual %h",
                                   field_label(i), want[5-i], got[5-i]);
                            errs++;
                        end
                    end
                    seen++;
                end
            end
            if (mid_valid && mid_ready)
            begin
                precalc_q.push_back(run_three_rounds(mid_data));
            end
        end
        fail_count    <= errs;
        pending       <= precalc_q.size();
        words_checked <= seen;
    end

endmodule

@@ verif/testbench.sv @@
// testbench: stimulus and verdict for sha256_three_round_precompute.
// Depends on s3rp_pkg, the block itself and s3rp_round_checker.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int N_RANDOM  = 800;
    localparam int N_FILL    = 24;
    localparam int LONG_HOLD = 40;

    logic                clk = 1'b0;
    logic                rst_n;
    logic                mid_valid;
    logic                mid_ready;
    s3rp_pkg::mid_word_t mid_data;
    logic                pre_valid;
    logic                pre_ready;
    s3rp_pkg::pre_word_t pre_data;

    int fail_count;
    int pending;
    int words_checked;
    int words_sent = 0;
    bit tx_idle_en = 1'b0;
    bit rx_idle_en = 1'b0;
    bit long_hold_req = 1'b0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    sha256_three_round_precompute i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .mid_valid (mid_valid),
        .mid_ready (mid_ready),
        .mid_data  (mid_data),
        .pre_valid (pre_valid),
        .pre_ready (pre_ready),
        .pre_data  (pre_data)
    );

    s3rp_round_checker i_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .mid_valid     (mid_valid),
        .mid_ready     (mid_ready),
        .mid_data      (mid_data),
        .pre_valid     (pre_valid),
        .pre_ready     (pre_ready),
        .pre_data      (pre_data),
        .fail_count    (fail_count),
        .pending       (pending),
        .words_checked (words_checked)
    );

    // Hard stop well past the slowest legal run
    initial
    begin
        #5_000_000;
        $display("sha256_three_round_precompute regression: fail");
        $finish;
    end

    // Result side: random stalls, one long hold on request, free flow otherwise
    initial
    begin
        pre_ready = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (long_hold_req)
            begin
                pre_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
                long_hold_req = 1'b0;
            end
            else if (rx_idle_en && $urandom_range(0, 4) == 0)
            begin
                pre_ready <= 1'b0;
                repeat ($urandom_range(1, 16)) @(posedge clk);
            end
            else
            begin
                pre_ready <= 1'b1;
                if (rx_idle_en)
                    repeat ($urandom_range(1, 20)) @(posedge clk);
                else
                    @(posedge clk);
            end
        end
    end

    // Mostly random words, with a share of corner patterns
    function automatic s3rp_pkg::word_t pick_word();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            2:       return s3rp_pkg::word_t'(32'h1) << $urandom_range(0, 31);
            3:       return ~(s3rp_pkg::word_t'(32'h1) << $urandom_range(0, 31));
            default: return $urandom();
        endcase
    endfunction

    function automatic s3rp_pkg::mid_word_t random_mid();
        logic [10:0][s3rp_pkg::WORD_W-1:0] flat;
        for (int i = 0; i < 11; i++)
        begin
            flat[i] = pick_word();
        end
        return s3rp_pkg::mid_word_t'(flat);
    endfunction

    // Offer one word, with an optional gap first; returns on acceptance
    task automatic send_word(input s3rp_pkg::mid_word_t w);
        int gap;
        if (tx_idle_en && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 16);
            mid_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        mid_valid <= 1'b1;
        mid_data  <= w;
        do @(posedge clk); while (!mid_ready);
        words_sent++;
    endtask

    task automatic drain_all();
        mid_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
    endtask

    initial
    begin
        logic [10:0][s3rp_pkg::WORD_W-1:0] flat;
        s3rp_pkg::mid_word_t               w;
        rst_n     = 1'b0;
        mid_valid = 1'b0;
        mid_data  = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: all zeros, all ones, the standard initial hash on "abc"
        send_word('0);
        send_word('1);
        w = '{32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
              32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19,
              32'h61626380, 32'h00000000, 32'h00000000};
        send_word(w);

        // Alternating bit patterns, both phases
        for (int i = 0; i < 11; i++)
        begin
            flat[i] = (i % 2) ? 32'haaaaaaaa : 32'h55555555;
        end
        send_word(s3rp_pkg::mid_word_t'(flat));
        send_word(s3rp_pkg::mid_word_t'(~flat));

        // One field saturated at a time, the rest zero
        for (int i = 0; i < 11; i++)
        begin
            flat    = '0;
            flat[i] = '1;
            send_word(s3rp_pkg::mid_word_t'(flat));
        end

        // Choose picks all of f, then all of g
        w       = random_mid();
        w.mid_e = '1;
        send_word(w);
        w       = random_mid();
        w.mid_e = '0;
        send_word(w);
        drain_all();

        // Hold the result side off while words keep coming, then drain
        long_hold_req = 1'b1;
        while (pre_ready) @(posedge clk);
        for (int i = 0; i < N_FILL; i++)
        begin
            send_word(random_mid());
        end
        drain_all();

        // Random traffic; idling alternates by stretch, none in the tail
        for (int k = 0; k < N_RANDOM; k++)
        begin
            tx_idle_en = (k < 600) && ((k / 100) % 2 == 0);
            rx_idle_en = (k < 600) && (((k + 50) / 100) % 2 == 0);
            send_word(random_mid());
        end
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
        drain_all();
        repeat (12) @(posedge clk);

        $display("Covered directed corners, a stalled-output fill and random traffic");
        $display("with idling on both sides: %0d words sent, %0d results compared.",
                 words_sent, words_checked);
        if (fail_count == 0 && pending == 0)
            $display("sha256_three_round_precompute regression: pass");
        else
            $display("sha256_three_round_precompute regression: fail");
        $finish;
    end

endmodule

@@ sha256_three_round_precompute.f @@
hdl/s3rp_pkg.sv
hdl/sha256_three_round_precompute.sv
verif/s3rp_round_checker.sv
verif/testbench.sv
